// File: hdl/mexp_pkg.sv
// shared types and constants for the modular exponentiation block
// no dependencies; used by every module under hdl
package mexp_pkg;

  localparam int unsigned MOD_W = 31;
  localparam int unsigned OPD_W = 63;
  localparam int unsigned DIV_W = 63;
  localparam int unsigned PROD_W = 2 * MOD_W;
  localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RBASE,
    ST_MULT,
    ST_RED,
    ST_FINISH
  } mexp_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic take_sq;
    logic mult;
    logic update;
    logic out_load;
  } mexp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic a_busy;
    logic b_busy;
    logic exp_zero;
    logic exp_last;
  } mexp_stat_t;

endpackage

// File: hdl/mexp_rem.sv
// bit-serial restoring remainder unit: dividend mod modulus, one bit per cycle
// depends on mexp_pkg for widths
module mexp_rem (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [mexp_pkg::DIV_W-1:0]  dividend,
  input  logic [mexp_pkg::MOD_W-1:0]  modulus,
  output logic                        busy,
  output logic [mexp_pkg::MOD_W-1:0]  remainder
);

  localparam int unsigned CW = $clog2(mexp_pkg::DIV_W + 1);

  logic [CW-1:0]               count;
  logic [mexp_pkg::DIV_W-1:0]  shreg;
  logic [mexp_pkg::MOD_W-1:0]  rem;
  logic [mexp_pkg::MOD_W:0]    trial;
  logic                        fits;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem, shreg[mexp_pkg::DIV_W-1]};
  assign fits = trial >= {1'b0, modulus};

  assign busy = count != '0;
  assign remainder = rem;

  // bit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CW'(mexp_pkg::DIV_W);
    end else if (busy) begin
      count <= count - 1'b1;
    end
  end

  // dividend shifter and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem <= '0;
    end else if (busy) begin
      shreg <= {shreg[mexp_pkg::DIV_W-2:0], 1'b0};
      if (fits) begin
        rem <= mexp_pkg::MOD_W'(trial - {1'b0, modulus});
      end else begin
        rem <= trial[mexp_pkg::MOD_W-1:0];
      end
    end
  end

endmodule

// File: hdl/mexp_dp.sv
// datapath: exponent shifter, accumulator, power, two multipliers, two remainder units
// depends on mexp_pkg and mexp_rem
module mexp_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  mexp_pkg::mexp_cmd_t         cmd,
  input  logic [mexp_pkg::OPD_W-1:0]  base,
  input  logic [mexp_pkg::OPD_W-1:0]  exponent,
  input  logic [mexp_pkg::MOD_W-1:0]  modulus,
  output mexp_pkg::mexp_stat_t        stat,
  output logic [mexp_pkg::MOD_W-1:0]  residue
);

  logic [mexp_pkg::OPD_W-1:0]   exp_sh;
  logic [mexp_pkg::MOD_W-1:0]   acc;
  logic [mexp_pkg::MOD_W-1:0]   sq;
  logic [mexp_pkg::PROD_W-1:0]  prod_a;
  logic [mexp_pkg::PROD_W-1:0]  prod_b;
  logic [mexp_pkg::DIV_W-1:0]   div_a;
  logic [mexp_pkg::DIV_W-1:0]   div_b;
  logic [mexp_pkg::MOD_W-1:0]   rem_a;
  logic [mexp_pkg::MOD_W-1:0]   rem_b;
  logic                         busy_a;
  logic                         busy_b;

  // products of the running result and the power, and of the power with itself
  assign prod_a = mexp_pkg::PROD_W'(acc) * mexp_pkg::PROD_W'(sq);
  assign prod_b = mexp_pkg::PROD_W'(sq) * mexp_pkg::PROD_W'(sq);

  // unit a reduces the base first, then the multiply product
  assign div_a = cmd.load ? base : mexp_pkg::DIV_W'(prod_a);
  assign div_b = mexp_pkg::DIV_W'(prod_b);

  mexp_rem u_rem_a (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.load | cmd.mult),
    .dividend  (div_a),
    .modulus   (modulus),
    .busy      (busy_a),
    .remainder (rem_a)
  );

  mexp_rem u_rem_b (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.mult),
    .dividend  (div_b),
    .modulus   (modulus),
    .busy      (busy_b),
    .remainder (rem_b)
  );

  // exponent shifter, running result and power
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      exp_sh <= exponent;
      acc <= mexp_pkg::MOD_W'(1);
    end else if (cmd.update) begin
      exp_sh <= exp_sh >> 1;
      if (exp_sh[0]) begin
        acc <= rem_a;
      end
    end
    if (cmd.take_sq) begin
      sq <= rem_a;
    end else if (cmd.update) begin
      sq <= rem_b;
    end
  end

  // status back to the controller
  always_comb begin
    stat.a_busy = busy_a;
    stat.b_busy = busy_b;
    stat.exp_zero = exp_sh == '0;
    stat.exp_last = exp_sh[mexp_pkg::OPD_W-1:1] == '0;
  end

  // a modulus below two gives zero for every item
  assign residue = (modulus < mexp_pkg::MOD_W'(2)) ? '0 : acc;

endmodule

// File: hdl/mexp_ctrl.sv
// controller state machine sequencing base reduction and square-and-multiply steps
// depends on mexp_pkg
module mexp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  out_free,
  input  mexp_pkg::mexp_stat_t  stat,
  output logic                  in_ready,
  output mexp_pkg::mexp_cmd_t   cmd
);

  mexp_pkg::mexp_state_t state;
  mexp_pkg::mexp_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mexp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mexp_pkg::ST_IDLE: begin
        if (in_valid) state_next = mexp_pkg::ST_RBASE;
      end
      mexp_pkg::ST_RBASE: begin
        if (!stat.a_busy) begin
          state_next = stat.exp_zero ? mexp_pkg::ST_FINISH : mexp_pkg::ST_MULT;
        end
      end
      mexp_pkg::ST_MULT: begin
        state_next = mexp_pkg::ST_RED;
      end
      mexp_pkg::ST_RED: begin
        if (!stat.a_busy) begin
          state_next = stat.exp_last ? mexp_pkg::ST_FINISH : mexp_pkg::ST_MULT;
        end
      end
      mexp_pkg::ST_FINISH: begin
        if (out_free) state_next = mexp_pkg::ST_IDLE;
      end
      default: state_next = mexp_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      mexp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      mexp_pkg::ST_RBASE: begin
        cmd.take_sq = !stat.a_busy;
      end
      mexp_pkg::ST_MULT: begin
        cmd.mult = 1'b1;
      end
      mexp_pkg::ST_RED: begin
        cmd.update = !stat.a_busy;
      end
      mexp_pkg::ST_FINISH: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: hdl/modular_exponentiation.sv
// modular exponentiation, right-to-left square and multiply, one item at a time
// one square-and-multiply step per exponent bit up to the highest set bit, none for a
// zero exponent; each step is paced by the bit-serial remainder units; a new item can
// be accepted in the cycle after the result enters the output register; rst (synchronous)
// sets modulus to 1000000007
// depends on mexp_pkg, mexp_ctrl, mexp_dp, mexp_rem
module modular_exponentiation (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [30:0]   cfg_data,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [127:0]  s_tdata,   // base [62:0], exponent [125:63], zero pad [127:126]
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [31:0]   m_tdata    // residue [30:0], zero pad [31]
);

  logic [mexp_pkg::MOD_W-1:0]  modulus;
  logic [mexp_pkg::MOD_W-1:0]  residue;
  logic [mexp_pkg::MOD_W-1:0]  res_out;
  logic                        out_free;
  mexp_pkg::mexp_cmd_t         cmd;
  mexp_pkg::mexp_stat_t        stat;

  // modulus register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= mexp_pkg::MODULUS_RESET;
    end else if (cfg_we) begin
      modulus <= cfg_data;
    end
  end

  assign out_free = !m_tvalid || m_tready;

  mexp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .out_free (out_free),
    .stat     (stat),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  mexp_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .base     (s_tdata[62:0]),
    .exponent (s_tdata[125:63]),
    .modulus  (modulus),
    .stat     (stat),
    .residue  (residue)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_out <= residue;
    end
  end

  assign m_tdata = {1'b0, res_out};

`ifndef SYNTHESIS
  // the square unit only runs alongside the multiply unit
  a_units_paired: assert property (@(posedge clk) disable iff (rst)
    stat.b_busy |-> stat.a_busy)
    else $error("square remainder unit busy without multiply unit");

  // an accepted item takes the controller out of idle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input still ready right after an accepted item");

  // a loaded residue is reduced below the modulus
  a_residue_reduced: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && modulus >= mexp_pkg::MOD_W'(2)) |=> (m_tdata[30:0] < $past(modulus)))
    else $error("residue not below modulus");
`endif

endmodule
